// ----- rtl/envelope_breakpoint_generator_macros.svh -----
// Assertion macros for the envelope breakpoint generator, used by ebg_seq.
`ifndef ENVELOPE_BREAKPOINT_GENERATOR_MACROS_SVH
`define ENVELOPE_BREAKPOINT_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define EBG_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("envelope breakpoint generator: assertion failed");

// Next-cycle implication.
`define EBG_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("envelope breakpoint generator: assertion failed");

`endif

// ----- rtl/ebg_pkg.sv -----
`timescale 1ns / 1ps

package ebg_pkg;

   localparam int unsigned DUR_W   = 15;
   localparam int unsigned TIME_W  = 16;
   localparam int unsigned LEVEL_W = 16;
   localparam int unsigned STEP_W  = 5;
   localparam int unsigned PROD_W  = 17;
   localparam int unsigned QUOT_W  = 15;
   localparam int unsigned RECIP_W = 33;

   localparam logic [DUR_W-1:0]   DUR_MAX    = 15'd20000;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 16'd32768;
   localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 16'd0;
   // ceil(2^18 / 5): exact floor(x / 5) for x below 2^18
   localparam logic [RECIP_W-1:0] RECIP_FIVE = 33'd52429;
   localparam int unsigned        RECIP_SHIFT = 18;

   localparam logic [1:0] CURVE_LINEAR = 2'd0;
   localparam logic [1:0] CURVE_CUBIC  = 2'd1;
   localparam logic [1:0] CURVE_FLIP   = 2'd2;
   localparam logic       HOLD_KEEP    = 1'b0;
   localparam logic       HOLD_DIP     = 1'b1;

   localparam logic [3:0][15:0] LVL_LINEAR = {16'd26214, 16'd19661, 16'd13107, 16'd6554};
   localparam logic [3:0][15:0] LVL_CUBIC  = {16'd16777, 16'd7078, 16'd2097, 16'd262};
   localparam logic [3:0][15:0] LVL_FLIP   = {16'd32506, 16'd30671, 16'd25690, 16'd15991};
   localparam logic [3:0][15:0] LVL_DIP    = {16'd4247, 16'd52, 16'd52, 16'd4247};

   localparam logic [STEP_W-1:0] STEP_START      = 5'd0;
   localparam logic [STEP_W-1:0] STEP_ATTACK_NIL = 5'd7;
   localparam logic [STEP_W-1:0] STEP_HOLD_TEST  = 5'd8;
   localparam logic [STEP_W-1:0] STEP_DECAY_TEST = 5'd14;
   localparam logic [STEP_W-1:0] STEP_END        = 5'd19;
   localparam logic [STEP_W-1:0] STEP_DONE       = 5'd20;

   typedef enum logic [1:0] {
      OP_TEST = 2'd0,
      OP_EMIT = 2'd1,
      OP_DONE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      T_ZERO  = 3'd0,
      T_A     = 3'd1,
      T_AH    = 3'd2,
      T_TOT   = 3'd3,
      T_INNER = 3'd4
   } tsel_type;

   typedef enum logic [2:0] {
      L_ZERO   = 3'd0,
      L_ONE    = 3'd1,
      L_RAMP_A = 3'd2,
      L_HOLD   = 3'd3,
      L_RAMP_D = 3'd4
   } lsel_type;

   typedef enum logic [1:0] {
      SEG_A = 2'd0,
      SEG_H = 2'd1,
      SEG_D = 2'd2
   } seg_type;

   typedef enum logic [2:0] {
      C_NEVER  = 3'd0,
      C_ALWAYS = 3'd1,
      C_TOT0   = 3'd2,
      C_A0     = 3'd3,
      C_H0     = 3'd4,
      C_D0     = 3'd5
   } cond_type;

   typedef enum logic [1:0] {
      LAST_NO   = 2'd0,
      LAST_YES  = 2'd1,
      LAST_COND = 2'd2
   } last_type;

   typedef struct packed {
      op_type            op;
      tsel_type          tsel;
      lsel_type          lsel;
      seg_type           seg;
      logic [2:0]        k;
      logic [1:0]        lidx;
      cond_type          cond;
      logic [STEP_W-1:0] target;
      last_type          last;
   } word_type;

   typedef struct packed {
      logic       capture;
      logic       mul_en;
      logic       div_en;
      logic       load_out;
      logic       last;
      tsel_type   tsel;
      lsel_type   lsel;
      seg_type    seg;
      logic [2:0] k;
      logic [1:0] lidx;
   } ctl_type;

   typedef struct packed {
      logic tot_zero;
      logic a_zero;
      logic h_zero;
      logic d_zero;
   } status_type;

   function automatic logic [DUR_W-1:0] sat_dur(input logic [DUR_W-1:0] v);
      return (v > DUR_MAX) ? DUR_MAX : v;
   endfunction

   function automatic logic [LEVEL_W-1:0] ramp_level(input logic [1:0] curve,
                                                     input logic [1:0] idx);
      logic [LEVEL_W-1:0] lvl;
      case (curve)
         CURVE_CUBIC: begin
            lvl = LVL_CUBIC[idx];
         end
         CURVE_FLIP: begin
            lvl = LVL_FLIP[idx];
         end
         default: begin
            lvl = LVL_LINEAR[idx];
         end
      endcase
      return lvl;
   endfunction

   function automatic logic [LEVEL_W-1:0] hold_level(input logic curve,
                                                     input logic [1:0] idx);
      return (curve == HOLD_DIP) ? LVL_DIP[idx] : LEVEL_ONE;
   endfunction

   function automatic word_type mk(input op_type op, input tsel_type tsel,
                                   input lsel_type lsel, input seg_type seg,
                                   input logic [2:0] k, input logic [1:0] lidx,
                                   input cond_type cond, input logic [STEP_W-1:0] target,
                                   input last_type last);
      word_type w;
      w.op     = op;
      w.tsel   = tsel;
      w.lsel   = lsel;
      w.seg    = seg;
      w.k      = k;
      w.lidx   = lidx;
      w.cond   = cond;
      w.target = target;
      w.last   = last;
      return w;
   endfunction

   function automatic word_type rom_word(input logic [STEP_W-1:0] step);
      word_type w;
      case (step)
         5'd0:  w = mk(OP_EMIT, T_ZERO, L_ZERO, SEG_A, 3'd0, 2'd0, C_TOT0,
                       STEP_DONE, LAST_COND);
         5'd1:  w = mk(OP_TEST, T_ZERO, L_ZERO, SEG_A, 3'd0, 2'd0, C_A0,
                       STEP_ATTACK_NIL, LAST_NO);
         5'd2:  w = mk(OP_EMIT, T_INNER, L_RAMP_A, SEG_A, 3'd1, 2'd0, C_NEVER,
                       STEP_START, LAST_NO);
         5'd3:  w = mk(OP_EMIT, T_INNER, L_RAMP_A, SEG_A, 3'd2, 2'd1, C_NEVER,
                       STEP_START, LAST_NO);
         5'd4:  w = mk(OP_EMIT, T_INNER, L_RAMP_A, SEG_A, 3'd3, 2'd2, C_NEVER,
                       STEP_START, LAST_NO);
         5'd5:  w = mk(OP_EMIT, T_INNER, L_RAMP_A, SEG_A, 3'd4, 2'd3, C_NEVER,
                       STEP_START, LAST_NO);
         5'd6:  w = mk(OP_EMIT, T_A, L_ONE, SEG_A, 3'd0, 2'd0, C_ALWAYS,
                       STEP_HOLD_TEST, LAST_NO);
         5'd7:  w = mk(OP_EMIT, T_ZERO, L_ONE, SEG_A, 3'd0, 2'd0, C_NEVER,
                       STEP_START, LAST_NO);
         5'd8:  w = mk(OP_TEST, T_ZERO, L_ZERO, SEG_H, 3'd0, 2'd0, C_H0,
                       STEP_DECAY_TEST, LAST_NO);
         5'd9:  w = mk(OP_EMIT, T_INNER, L_HOLD, SEG_H, 3'd1, 2'd0, C_NEVER,
                       STEP_START, LAST_NO);
         5'd10: w = mk(OP_EMIT, T_INNER, L_HOLD, SEG_H, 3'd2, 2'd1, C_NEVER,
                       STEP_START, LAST_NO);
         5'd11: w = mk(OP_EMIT, T_INNER, L_HOLD, SEG_H, 3'd3, 2'd2, C_NEVER,
                       STEP_START, LAST_NO);
         5'd12: w = mk(OP_EMIT, T_INNER, L_HOLD, SEG_H, 3'd4, 2'd3, C_NEVER,
                       STEP_START, LAST_NO);
         5'd13: w = mk(OP_EMIT, T_AH, L_ONE, SEG_H, 3'd0, 2'd0, C_NEVER,
                       STEP_START, LAST_NO);
         5'd14: w = mk(OP_TEST, T_ZERO, L_ZERO, SEG_D, 3'd0, 2'd0, C_D0,
                       STEP_END, LAST_NO);
         5'd15: w = mk(OP_EMIT, T_INNER, L_RAMP_D, SEG_D, 3'd1, 2'd3, C_NEVER,
                       STEP_START, LAST_NO);
         5'd16: w = mk(OP_EMIT, T_INNER, L_RAMP_D, SEG_D, 3'd2, 2'd2, C_NEVER,
                       STEP_START, LAST_NO);
         5'd17: w = mk(OP_EMIT, T_INNER, L_RAMP_D, SEG_D, 3'd3, 2'd1, C_NEVER,
                       STEP_START, LAST_NO);
         5'd18: w = mk(OP_EMIT, T_INNER, L_RAMP_D, SEG_D, 3'd4, 2'd0, C_NEVER,
                       STEP_START, LAST_NO);
         5'd19: w = mk(OP_EMIT, T_TOT, L_ZERO, SEG_D, 3'd0, 2'd0, C_NEVER,
                       STEP_START, LAST_YES);
         default: w = mk(OP_DONE, T_ZERO, L_ZERO, SEG_A, 3'd0, 2'd0, C_NEVER,
                         STEP_START, LAST_NO);
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/ebg_dp.sv -----
`timescale 1ns / 1ps

module ebg_dp (
   input  logic                             clock,
   input  ebg_pkg::ctl_type                 ctl,
   input  logic [ebg_pkg::DUR_W-1:0]        attack_us,
   input  logic [1:0]                       attack_curve,
   input  logic [ebg_pkg::DUR_W-1:0]        hold_us,
   input  logic                             hold_curve,
   input  logic [ebg_pkg::DUR_W-1:0]        decay_us,
   input  logic [1:0]                       decay_curve,
   output ebg_pkg::status_type              status,
   output logic [ebg_pkg::TIME_W-1:0]       point_time,
   output logic [ebg_pkg::LEVEL_W-1:0]      point_level
);

   logic [ebg_pkg::DUR_W-1:0]   a_ff, h_ff, d_ff;
   logic [ebg_pkg::DUR_W-1:0]   a_in, h_in, d_in;
   logic [1:0]                  ac_ff, dc_ff;
   logic                        hc_ff;
   logic [ebg_pkg::TIME_W-1:0]  ah_ff, tot_ff, ah_in, tot_in;
   logic [ebg_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [ebg_pkg::QUOT_W-1:0]  quot_ff, quot_in;
   logic [ebg_pkg::RECIP_W-1:0] recip_prod;
   logic [ebg_pkg::DUR_W-1:0]   dur;
   logic [ebg_pkg::TIME_W-1:0]  base;

   assign a_in   = ebg_pkg::sat_dur(attack_us);
   assign h_in   = ebg_pkg::sat_dur(hold_us);
   assign d_in   = ebg_pkg::sat_dur(decay_us);
   assign ah_in  = {1'b0, a_in} + {1'b0, h_in};
   assign tot_in = ah_in + {1'b0, d_in};

   always_comb begin
      case (ctl.seg)
         ebg_pkg::SEG_H: begin
            dur  = h_ff;
            base = {1'b0, a_ff};
         end
         ebg_pkg::SEG_D: begin
            dur  = d_ff;
            base = ah_ff;
         end
         default: begin
            dur  = a_ff;
            base = '0;
         end
      endcase
   end

   assign prod_in    = ebg_pkg::PROD_W'(ctl.k) * ebg_pkg::PROD_W'(dur);
   assign recip_prod = ebg_pkg::RECIP_W'(prod_ff) * ebg_pkg::RECIP_FIVE;
   assign quot_in    = recip_prod[ebg_pkg::RECIP_SHIFT +: ebg_pkg::QUOT_W];

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         a_ff   <= a_in;
         h_ff   <= h_in;
         d_ff   <= d_in;
         ac_ff  <= attack_curve;
         hc_ff  <= hold_curve;
         dc_ff  <= decay_curve;
         ah_ff  <= ah_in;
         tot_ff <= tot_in;
      end
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.div_en) begin
         quot_ff <= quot_in;
      end
   end

   always_comb begin
      case (ctl.tsel)
         ebg_pkg::T_A:     point_time = {1'b0, a_ff};
         ebg_pkg::T_AH:    point_time = ah_ff;
         ebg_pkg::T_TOT:   point_time = tot_ff;
         ebg_pkg::T_INNER: point_time = base + ebg_pkg::TIME_W'(quot_ff);
         default:          point_time = '0;
      endcase
   end

   always_comb begin
      case (ctl.lsel)
         ebg_pkg::L_ONE:    point_level = ebg_pkg::LEVEL_ONE;
         ebg_pkg::L_RAMP_A: point_level = ebg_pkg::ramp_level(ac_ff, ctl.lidx);
         ebg_pkg::L_HOLD:   point_level = ebg_pkg::hold_level(hc_ff, ctl.lidx);
         ebg_pkg::L_RAMP_D: point_level = ebg_pkg::ramp_level(dc_ff, ctl.lidx);
         default:           point_level = ebg_pkg::LEVEL_ZERO;
      endcase
   end

   assign status.tot_zero = (tot_ff == '0);
   assign status.a_zero   = (a_ff == '0);
   assign status.h_zero   = (h_ff == '0);
   assign status.d_zero   = (d_ff == '0);

endmodule

// ----- rtl/ebg_seq.sv -----
`timescale 1ns / 1ps
`include "envelope_breakpoint_generator_macros.svh"

module ebg_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                out_free,
   input  ebg_pkg::status_type status,
   output ebg_pkg::ctl_type    ctl
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RUN  = 4'b0010,
      S_DIV  = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [ebg_pkg::STEP_W-1:0]    step_ff, step_in, next_step;
   ebg_pkg::word_type             word;
   logic                          cond_true;

   always_comb begin
      word = ebg_pkg::rom_word(step_ff);
      case (word.cond)
         ebg_pkg::C_ALWAYS: cond_true = 1'b1;
         ebg_pkg::C_TOT0:   cond_true = status.tot_zero;
         ebg_pkg::C_A0:     cond_true = status.a_zero;
         ebg_pkg::C_H0:     cond_true = status.h_zero;
         ebg_pkg::C_D0:     cond_true = status.d_zero;
         default:           cond_true = 1'b0;
      endcase
      next_step = cond_true ? word.target : ebg_pkg::STEP_W'(step_ff + 5'd1);
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ctl          = '0;
      ctl.tsel     = word.tsel;
      ctl.lsel     = word.lsel;
      ctl.seg      = word.seg;
      ctl.k        = word.k;
      ctl.lidx     = word.lidx;
      ctl.last     = (word.last == ebg_pkg::LAST_YES) ||
                     ((word.last == ebg_pkg::LAST_COND) && cond_true);
      case (state_ff)
         S_IDLE: begin
            ctl.capture = req_valid;
            if (req_valid) begin
               state_in = S_RUN;
               step_in  = ebg_pkg::STEP_START;
            end
         end
         S_RUN: begin
            case (word.op)
               ebg_pkg::OP_TEST: begin
                  step_in = next_step;
               end
               ebg_pkg::OP_EMIT: begin
                  if (word.tsel == ebg_pkg::T_INNER) begin
                     ctl.mul_en = 1'b1;
                     state_in   = S_DIV;
                  end else begin
                     state_in = S_EMIT;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DIV: begin
            ctl.div_en = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               ctl.load_out = 1'b1;
               step_in      = next_step;
               state_in     = S_RUN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= ebg_pkg::STEP_START;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   `EBG_ASSERT_IMP(a_step_range, clock, reset, state_ff != S_IDLE, step_ff <= ebg_pkg::STEP_DONE)
   `EBG_ASSERT_IMP(a_load_free, clock, reset, ctl.load_out, out_free)
   `EBG_ASSERT_NEXT(a_start, clock, reset, req_valid && req_ready, state_ff == S_RUN && step_ff == ebg_pkg::STEP_START)
   `EBG_ASSERT_NEXT(a_last_done, clock, reset, ctl.load_out && ctl.last, step_ff == ebg_pkg::STEP_DONE)

endmodule

// ----- rtl/envelope_breakpoint_generator.sv -----
`timescale 1ns / 1ps

// Attack-hold-decay envelope breakpoint generator. One request carries three
// durations in microseconds (each saturated to 20000) with a curve shape per
// segment, and yields 1 to 16 (time, level) breakpoints, level in Q1.15, with
// rsp_last_point set on the final one. A microcode program of 21 steps walks
// the segments; a test step only picks the next step, a segment end point is
// loaded from the emit state, and an inner point is first computed (multiply
// by k, then multiply by the reciprocal of five). Loading a breakpoint stalls
// while the response register holds one that is not yet taken. After the last
// breakpoint is loaded the sequencer runs its done step and returns to idle,
// where a new request can be accepted; that breakpoint may still wait in the
// response register.
module envelope_breakpoint_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [14:0] req_attack_us,
   input  logic [1:0]  req_attack_curve,
   input  logic [14:0] req_hold_us,
   input  logic        req_hold_curve,
   input  logic [14:0] req_decay_us,
   input  logic [1:0]  req_decay_curve,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_point_time_us,
   output logic [15:0] rsp_point_level,
   output logic        rsp_last_point
);

   ebg_pkg::ctl_type    ctl;
   ebg_pkg::status_type status;
   logic [15:0]         point_time, point_level;
   logic                out_free;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         time_ff, level_ff;
   logic                last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   ebg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .status    (status),
      .ctl       (ctl)
   );

   ebg_dp u_dp (
      .clock        (clock),
      .ctl          (ctl),
      .attack_us    (req_attack_us),
      .attack_curve (req_attack_curve),
      .hold_us      (req_hold_us),
      .hold_curve   (req_hold_curve),
      .decay_us     (req_decay_us),
      .decay_curve  (req_decay_curve),
      .status       (status),
      .point_time   (point_time),
      .point_level  (point_level)
   );

   assign rsp_valid_in = ctl.load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         time_ff  <= point_time;
         level_ff <= point_level;
         last_ff  <= ctl.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_point_time_us = time_ff;
   assign rsp_point_level   = level_ff;
   assign rsp_last_point    = last_ff;

endmodule
